// ===== hdl/mcq_pkg.sv =====
package mcq_pkg;

  // Opcodes carried in tuser of the input stream.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_TARGET  = 1'b0;
  localparam logic CFG_PALSIZE = 1'b1;

  localparam int TARGET_W  = 7;
  localparam int PALSIZE_W = 9;
  localparam logic [TARGET_W-1:0]  TARGET_RST  = 7'd16;
  localparam logic [PALSIZE_W-1:0] PALSIZE_RST = 9'd256;

  // Color axis codes.
  localparam logic [1:0] AX_RED   = 2'd0;
  localparam logic [1:0] AX_GREEN = 2'd1;
  localparam logic [1:0] AX_BLUE  = 2'd2;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_CNT, ST_GATHER, ST_DECIDE, ST_EMPTY_WT,
    ST_PASS_RD, ST_PASS_LD, ST_PASS_WT,
    ST_BND_GO, ST_BND_RD, ST_BND_WR,
    ST_SR_GO, ST_SR_RD, ST_SR_END,
    ST_SO_RD, ST_SO_T, ST_SO_CR, ST_SO_CMP, ST_SO_PUT,
    ST_SP_GO, ST_SP_RD, ST_SP_END, ST_OLD, ST_INC,
    ST_AV_GO, ST_AV_BRD, ST_AV_BLD, ST_AV_RD, ST_AV_E, ST_AV_M, ST_AV_A,
    ST_DV_GO, ST_DV_WT, ST_AV_OUT, ST_AV_WT
  } state_e;

  // Colors are packed red in the low byte, then green, then blue.
  function automatic logic [7:0] chan_sel(input logic [23:0] rgb, input logic [1:0] ax);
    logic [7:0] v;
    case (ax)
      AX_RED:   v = rgb[7:0];
      AX_GREEN: v = rgb[15:8];
      default:  v = rgb[23:16];
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/mcq_ram.sv =====
module mcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mcq_div.sv =====
// Restoring divider for a quotient known to fit in eight bits; one bit per cycle.
module mcq_div #(
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W+7:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [7:0]       quot_o
);

  logic [DEN_W+7:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [7:0]       quot_q, quot_d;
  logic [2:0]       step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W+7:0] trial;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = (DEN_W + 8)'(den_q) << step_q;
    if (start_i) begin
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
      step_d = 3'd7;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d          = rem_q - trial;
        quot_d[step_q] = 1'b1;
      end
      if (step_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    step_q <= step_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/median_cut_palette_quantizer_core.sv =====
// Channel   Direction  Signals                          Word layout
// s_axis    in         tvalid/tready/tdata/tuser        tdata: index, red, green, blue
//                                                       tuser: opcode
// m_axis    out        tvalid/tready/tdata/tuser/tlast  tdata: color_slot, red, green, blue
//                                                       tuser: empty_result, tlast: last
// cfg       in         cfg_we_i/cfg_addr_i/cfg_data_i   0: output color target, 1: entry limit
//
// A palette load writes the palette RAM directly; a pixel count is a read-modify-write of the
// count RAM. A run first gathers used colors, then per split runs a box search, an insertion
// sort, a median scan and two bounding passes, then per box accumulates every entry on the
// shared multiplier and divides each channel on the divider.
// After reset the count RAM is cleared with s_axis_tready low.
// Each output word waits in the output register until m_axis_tready takes it.
module median_cut_palette_quantizer_core #(
  parameter int MAX_BOXES     = 64,
  parameter int PALETTE_DEPTH = 256,
  parameter int COUNT_BITS    = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // color_slot[5:0], red[13:6], green[21:14], blue[29:22]
  output logic        m_axis_tuser,   // empty_result
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int IW  = $clog2(PALETTE_DEPTH);
  localparam int BW  = $clog2(MAX_BOXES);
  localparam int CTW = ((IW > BW) ? IW : BW) + 1;
  localparam int KW  = CTW + 7;
  localparam int WW  = COUNT_BITS + IW;
  localparam int SW  = WW + 8;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [23:0]           rgb;
  } hist_t;

  typedef struct packed {
    logic [IW-1:0] first;
    logic [IW:0]   len;
    logic [7:0]    rng;
    logic [1:0]    axis;
    logic [WW-1:0] weight;
  } box_t;

  mcq_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [mcq_pkg::TARGET_W-1:0]  target_q, target_d, tgt_eff;
  logic [mcq_pkg::PALSIZE_W-1:0] palsize_q, palsize_d;
  logic [CTW-1:0]  ctr_q, ctr_d, gidx, slot_q, slot_d;
  logic [IW:0]     used_q, used_d, j_q, j_d, split_q, split_d, sp;
  logic [BW:0]     total_q, total_d;
  logic [BW-1:0]   best_q, best_d, bnd_slot_q, bnd_slot_d;
  logic [7:0]      best_rng_q, best_rng_d;
  box_t            bbox_q, bbox_d;
  logic [IW-1:0]   bnd_first_q, bnd_first_d, cnt_idx_q, cnt_idx_d;
  logic [IW:0]     bnd_len_q, bnd_len_d;
  logic [2:0][7:0] lo_q, lo_d, hi_q, hi_d, rg;
  logic [WW-1:0]   wsum_q, wsum_d, run_q, run_d, tot_q, tot_d, run_nx;
  hist_t           t_q, t_d, e_q, e_d;
  logic [1:0]      ch_q, ch_d, ax;
  logic [COUNT_BITS+7:0] prod_q, prod_d;
  logic [2:0][SW-1:0] s_q, s_d;
  logic [2:0][7:0] col_q, col_d;
  logic            out_valid_q, out_valid_d, out_empty_q, out_empty_d;
  logic            out_last_q, out_last_d;
  logic [5:0]      out_slot_q, out_slot_d;
  logic [23:0]     out_rgb_q, out_rgb_d;

  logic [1:0]  in_op;
  logic [7:0]  in_idx;
  logic [23:0] in_rgb;
  logic        s_acc, out_acc;

  logic                  pal_we;
  logic [IW-1:0]         pal_waddr, pal_raddr;
  logic [23:0]           pal_rd;
  logic                  freq_we;
  logic [IW-1:0]         freq_waddr, freq_raddr;
  logic [COUNT_BITS-1:0] freq_wdata, freq_rd;
  logic                  hist_we;
  logic [IW-1:0]         hist_waddr, hist_raddr;
  hist_t                 hist_wdata, hist_rd;
  logic                  box_we;
  logic [BW-1:0]         box_raddr;
  box_t                  box_wdata, box_rd;
  logic                  div_start, div_done;
  logic [7:0]            div_q;

  assign in_op   = s_axis_tuser;
  assign in_idx  = s_axis_tdata[7:0];
  assign in_rgb  = s_axis_tdata[31:8];
  assign s_axis_tready = (state_q == mcq_pkg::ST_IDLE);
  assign s_acc   = s_axis_tvalid & s_axis_tready;
  assign out_acc = out_valid_q & m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_rgb_q, out_slot_q};
  assign m_axis_tuser  = out_empty_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    if (target_q == '0) begin
      tgt_eff = mcq_pkg::TARGET_W'(1);
    end else if (target_q > mcq_pkg::TARGET_W'(MAX_BOXES)) begin
      tgt_eff = mcq_pkg::TARGET_W'(MAX_BOXES);
    end else begin
      tgt_eff = target_q;
    end
  end

  // The user must write configuration only while the block is idle; the block does not enforce this.
  always_comb begin
    target_d  = target_q;
    palsize_d = palsize_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        mcq_pkg::CFG_TARGET:  target_d  = cfg_data_i[mcq_pkg::TARGET_W-1:0];
        mcq_pkg::CFG_PALSIZE: palsize_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rg[a] = hi_q[a] - lo_q[a];
    end
    if (rg[0] >= rg[1] && rg[0] >= rg[2]) begin
      ax = mcq_pkg::AX_RED;
    end else if (rg[1] >= rg[2]) begin
      ax = mcq_pkg::AX_GREEN;
    end else begin
      ax = mcq_pkg::AX_BLUE;
    end
  end

  assign gidx   = ctr_q - CTW'(1);
  assign run_nx = run_q + WW'(hist_rd.cnt);
  assign sp     = (split_q == '0) ? (IW + 1)'(1)
                : ((split_q >= bbox_q.len) ? bbox_q.len - (IW + 1)'(1) : split_q);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    ctr_d       = ctr_q;
    slot_d      = slot_q;
    used_d      = used_q;
    j_d         = j_q;
    split_d     = split_q;
    total_d     = total_q;
    best_d      = best_q;
    best_rng_d  = best_rng_q;
    bbox_d      = bbox_q;
    bnd_first_d = bnd_first_q;
    bnd_len_d   = bnd_len_q;
    bnd_slot_d  = bnd_slot_q;
    cnt_idx_d   = cnt_idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    wsum_d      = wsum_q;
    run_d       = run_q;
    tot_d       = tot_q;
    t_d         = t_q;
    e_d         = e_q;
    ch_d        = ch_q;
    prod_d      = prod_q;
    s_d         = s_q;
    col_d       = col_q;
    out_valid_d = out_valid_q & ~out_acc;
    out_empty_d = out_empty_q;
    out_last_d  = out_last_q;
    out_slot_d  = out_slot_q;
    out_rgb_d   = out_rgb_q;

    pal_we     = 1'b0;
    pal_waddr  = in_idx[IW-1:0];
    pal_raddr  = ctr_q[IW-1:0];
    freq_we    = 1'b0;
    freq_waddr = ctr_q[IW-1:0];
    freq_wdata = '0;
    freq_raddr = ctr_q[IW-1:0];
    hist_we    = 1'b0;
    hist_waddr = used_q[IW-1:0];
    hist_wdata = hist_t'({freq_rd, pal_rd});
    hist_raddr = bbox_q.first + ctr_q[IW-1:0];
    box_we     = 1'b0;
    box_raddr  = ctr_q[BW-1:0];
    box_wdata  = box_t'({bnd_first_q, bnd_len_q, rg[ax], ax, wsum_q});
    div_start  = 1'b0;

    case (state_q)
      mcq_pkg::ST_CLEAR: begin
        freq_we = 1'b1;
        if (ctr_q == CTW'(PALETTE_DEPTH - 1)) begin
          ctr_d   = '0;
          state_d = mcq_pkg::ST_IDLE;
        end else begin
          ctr_d = ctr_q + CTW'(1);
        end
      end

      mcq_pkg::ST_IDLE: begin
        freq_raddr = in_idx[IW-1:0];
        pal_we = s_acc && (in_op == mcq_pkg::OP_LOAD)
              && (KW'(in_idx) < KW'(PALETTE_DEPTH));
        if (s_acc) begin
          case (in_op)
            mcq_pkg::OP_COUNT: begin
              if (KW'(in_idx) < KW'(palsize_q) && KW'(in_idx) < KW'(PALETTE_DEPTH)) begin
                cnt_idx_d = in_idx[IW-1:0];
                state_d   = mcq_pkg::ST_CNT;
              end
            end
            mcq_pkg::OP_RUN: begin
              ctr_d   = '0;
              used_d  = '0;
              state_d = mcq_pkg::ST_GATHER;
            end
            default: ;
          endcase
        end
      end

      mcq_pkg::ST_CNT: begin
        freq_waddr = cnt_idx_q;
        freq_wdata = freq_rd + COUNT_BITS'(1);
        freq_we    = ~&freq_rd;
        state_d    = mcq_pkg::ST_IDLE;
      end

      // Read data is registered, so entry ctr-1 is handled here
      // and its count is cleared for the next frame.
      mcq_pkg::ST_GATHER: begin
        if (ctr_q != '0) begin
          freq_we    = 1'b1;
          freq_waddr = gidx[IW-1:0];
          if (KW'(gidx) < KW'(palsize_q) && freq_rd != '0) begin
            hist_we = 1'b1;
            used_d  = used_q + (IW + 1)'(1);
          end
        end
        if (ctr_q == CTW'(PALETTE_DEPTH)) begin
          state_d = mcq_pkg::ST_DECIDE;
        end else begin
          ctr_d = ctr_q + CTW'(1);
        end
      end

      mcq_pkg::ST_DECIDE: begin
        slot_d = '0;
        if (used_q == '0) begin
          out_valid_d = 1'b1;
          out_slot_d  = '0;
          out_rgb_d   = '0;
          out_empty_d = 1'b1;
          out_last_d  = 1'b1;
          state_d     = mcq_pkg::ST_EMPTY_WT;
        end else if (KW'(used_q) <= KW'(tgt_eff)) begin
          state_d = mcq_pkg::ST_PASS_RD;
        end else begin
          bnd_first_d = '0;
          bnd_len_d   = used_q;
          bnd_slot_d  = '0;
          total_d     = (BW + 1)'(1);
          ret_d       = mcq_pkg::ST_SR_GO;
          state_d     = mcq_pkg::ST_BND_GO;
        end
      end

      mcq_pkg::ST_EMPTY_WT: begin
        if (out_acc) begin
          state_d = mcq_pkg::ST_IDLE;
        end
      end

      mcq_pkg::ST_PASS_RD: begin
        hist_raddr = slot_q[IW-1:0];
        state_d    = mcq_pkg::ST_PASS_LD;
      end

      mcq_pkg::ST_PASS_LD: begin
        out_valid_d = 1'b1;
        out_slot_d  = 6'(slot_q);
        out_rgb_d   = hist_rd.rgb;
        out_empty_d = 1'b0;
        out_last_d  = (KW'(slot_q) + KW'(1) == KW'(used_q));
        state_d     = mcq_pkg::ST_PASS_WT;
      end

      mcq_pkg::ST_PASS_WT: begin
        if (out_acc) begin
          if (out_last_q) begin
            state_d = mcq_pkg::ST_IDLE;
          end else begin
            slot_d  = slot_q + CTW'(1);
            state_d = mcq_pkg::ST_PASS_RD;
          end
        end
      end

      mcq_pkg::ST_BND_GO: begin
        ctr_d   = '0;
        lo_d    = {3{8'hFF}};
        hi_d    = '0;
        wsum_d  = '0;
        state_d = mcq_pkg::ST_BND_RD;
      end

      mcq_pkg::ST_BND_RD: begin
        hist_raddr = bnd_first_q + ctr_q[IW-1:0];
        if (ctr_q != '0) begin
          for (int a = 0; a < 3; a++) begin
            if (hist_rd.rgb[a*8 +: 8] < lo_q[a]) lo_d[a] = hist_rd.rgb[a*8 +: 8];
            if (hist_rd.rgb[a*8 +: 8] > hi_q[a]) hi_d[a] = hist_rd.rgb[a*8 +: 8];
          end
          wsum_d = wsum_q + WW'(hist_rd.cnt);
        end
        if (ctr_q == CTW'(bnd_len_q)) begin
          state_d = mcq_pkg::ST_BND_WR;
        end else begin
          ctr_d = ctr_q + CTW'(1);
        end
      end

      mcq_pkg::ST_BND_WR: begin
        box_we  = 1'b1;
        state_d = ret_q;
      end

      mcq_pkg::ST_SR_GO: begin
        if (KW'(total_q) >= KW'(tgt_eff)) begin
          state_d = mcq_pkg::ST_AV_GO;
        end else begin
          ctr_d      = '0;
          best_d     = '0;
          best_rng_d = '0;
          state_d    = mcq_pkg::ST_SR_RD;
        end
      end

      // The first box of the largest range wins, so only a strictly larger one replaces it.
      mcq_pkg::ST_SR_RD: begin
        if (ctr_q != '0) begin
          if (box_rd.len > (IW + 1)'(1) && box_rd.rng > best_rng_q) begin
            best_d     = gidx[BW-1:0];
            best_rng_d = box_rd.rng;
            bbox_d     = box_rd;
          end
        end
        if (ctr_q == CTW'(total_q)) begin
          state_d = mcq_pkg::ST_SR_END;
        end else begin
          ctr_d = ctr_q + CTW'(1);
        end
      end

      mcq_pkg::ST_SR_END: begin
        if (best_rng_q == '0) begin
          state_d = mcq_pkg::ST_AV_GO;
        end else begin
          ctr_d   = CTW'(1);
          state_d = mcq_pkg::ST_SO_RD;
        end
      end

      // Stable insertion sort of the chosen box along its axis.
      mcq_pkg::ST_SO_RD: begin
        state_d = mcq_pkg::ST_SO_T;
      end

      mcq_pkg::ST_SO_T: begin
        t_d     = hist_rd;
        j_d     = ctr_q[IW:0];
        state_d = mcq_pkg::ST_SO_CR;
      end

      mcq_pkg::ST_SO_CR: begin
        hist_raddr = bbox_q.first + j_q[IW-1:0] - IW'(1);
        if (j_q == '0) begin
          state_d = mcq_pkg::ST_SO_PUT;
        end else begin
          state_d = mcq_pkg::ST_SO_CMP;
        end
      end

      mcq_pkg::ST_SO_CMP: begin
        hist_waddr = bbox_q.first + j_q[IW-1:0];
        hist_wdata = hist_rd;
        if (mcq_pkg::chan_sel(hist_rd.rgb, bbox_q.axis)
            > mcq_pkg::chan_sel(t_q.rgb, bbox_q.axis)) begin
          hist_we = 1'b1;
          j_d     = j_q - (IW + 1)'(1);
          state_d = mcq_pkg::ST_SO_CR;
        end else begin
          state_d = mcq_pkg::ST_SO_PUT;
        end
      end

      mcq_pkg::ST_SO_PUT: begin
        hist_we    = 1'b1;
        hist_waddr = bbox_q.first + j_q[IW-1:0];
        hist_wdata = t_q;
        ctr_d      = ctr_q + CTW'(1);
        if (KW'(ctr_q) + KW'(1) == KW'(bbox_q.len)) begin
          state_d = mcq_pkg::ST_SP_GO;
        end else begin
          state_d = mcq_pkg::ST_SO_RD;
        end
      end

      mcq_pkg::ST_SP_GO: begin
        ctr_d   = '0;
        run_d   = '0;
        split_d = '0;
        state_d = mcq_pkg::ST_SP_RD;
      end

      // Split after the first entry whose running weight reaches half the box.
      mcq_pkg::ST_SP_RD: begin
        if (ctr_q == CTW'(bbox_q.len)) begin
          state_d = mcq_pkg::ST_SP_END;
        end else begin
          ctr_d = ctr_q + CTW'(1);
          if (ctr_q != '0) begin
            run_d = run_nx;
            if (run_nx >= (bbox_q.weight >> 1)) begin
              split_d = ctr_q[IW:0];
              state_d = mcq_pkg::ST_SP_END;
            end
          end
        end
      end

      mcq_pkg::ST_SP_END: begin
        split_d     = sp;
        bnd_first_d = bbox_q.first + sp[IW-1:0];
        bnd_len_d   = bbox_q.len - sp;
        bnd_slot_d  = total_q[BW-1:0];
        ret_d       = mcq_pkg::ST_OLD;
        state_d     = mcq_pkg::ST_BND_GO;
      end

      mcq_pkg::ST_OLD: begin
        bnd_first_d = bbox_q.first;
        bnd_len_d   = split_q;
        bnd_slot_d  = best_q;
        ret_d       = mcq_pkg::ST_INC;
        state_d     = mcq_pkg::ST_BND_GO;
      end

      mcq_pkg::ST_INC: begin
        total_d = total_q + (BW + 1)'(1);
        state_d = mcq_pkg::ST_SR_GO;
      end

      mcq_pkg::ST_AV_GO: begin
        slot_d  = '0;
        state_d = mcq_pkg::ST_AV_BRD;
      end

      mcq_pkg::ST_AV_BRD: begin
        box_raddr = slot_q[BW-1:0];
        state_d   = mcq_pkg::ST_AV_BLD;
      end

      mcq_pkg::ST_AV_BLD: begin
        bbox_d  = box_rd;
        s_d     = '0;
        tot_d   = '0;
        ctr_d   = '0;
        state_d = mcq_pkg::ST_AV_RD;
      end

      mcq_pkg::ST_AV_RD: begin
        state_d = mcq_pkg::ST_AV_E;
      end

      mcq_pkg::ST_AV_E: begin
        e_d     = hist_rd;
        tot_d   = tot_q + WW'(hist_rd.cnt);
        ch_d    = mcq_pkg::AX_RED;
        state_d = mcq_pkg::ST_AV_M;
      end

      mcq_pkg::ST_AV_M: begin
        prod_d  = (COUNT_BITS + 8)'(mcq_pkg::chan_sel(e_q.rgb, ch_q))
                * (COUNT_BITS + 8)'(e_q.cnt);
        state_d = mcq_pkg::ST_AV_A;
      end

      mcq_pkg::ST_AV_A: begin
        s_d[ch_q] = s_q[ch_q] + SW'(prod_q);
        if (ch_q == mcq_pkg::AX_BLUE) begin
          ctr_d = ctr_q + CTW'(1);
          if (KW'(ctr_q) + KW'(1) == KW'(bbox_q.len)) begin
            ch_d    = mcq_pkg::AX_RED;
            state_d = mcq_pkg::ST_DV_GO;
          end else begin
            state_d = mcq_pkg::ST_AV_RD;
          end
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = mcq_pkg::ST_AV_M;
        end
      end

      mcq_pkg::ST_DV_GO: begin
        div_start = 1'b1;
        state_d   = mcq_pkg::ST_DV_WT;
      end

      mcq_pkg::ST_DV_WT: begin
        if (div_done) begin
          col_d[ch_q] = (tot_q == '0) ? 8'd0 : div_q;
          if (ch_q == mcq_pkg::AX_BLUE) begin
            state_d = mcq_pkg::ST_AV_OUT;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = mcq_pkg::ST_DV_GO;
          end
        end
      end

      mcq_pkg::ST_AV_OUT: begin
        out_valid_d = 1'b1;
        out_slot_d  = 6'(slot_q);
        out_rgb_d   = col_q;
        out_empty_d = 1'b0;
        out_last_d  = (KW'(slot_q) + KW'(1) == KW'(total_q));
        state_d     = mcq_pkg::ST_AV_WT;
      end

      mcq_pkg::ST_AV_WT: begin
        if (out_acc) begin
          if (out_last_q) begin
            state_d = mcq_pkg::ST_IDLE;
          end else begin
            slot_d  = slot_q + CTW'(1);
            state_d = mcq_pkg::ST_AV_BRD;
          end
        end
      end

      default: begin
        state_d = mcq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcq_pkg::ST_CLEAR;
      ctr_q       <= '0;
      target_q    <= mcq_pkg::TARGET_RST;
      palsize_q   <= mcq_pkg::PALSIZE_RST;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      target_q    <= target_d;
      palsize_q   <= palsize_d;
      used_q      <= used_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q       <= ret_d;
    slot_q      <= slot_d;
    j_q         <= j_d;
    split_q     <= split_d;
    best_q      <= best_d;
    best_rng_q  <= best_rng_d;
    bbox_q      <= bbox_d;
    bnd_first_q <= bnd_first_d;
    bnd_len_q   <= bnd_len_d;
    bnd_slot_q  <= bnd_slot_d;
    cnt_idx_q   <= cnt_idx_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    wsum_q      <= wsum_d;
    run_q       <= run_d;
    tot_q       <= tot_d;
    t_q         <= t_d;
    e_q         <= e_d;
    ch_q        <= ch_d;
    prod_q      <= prod_d;
    s_q         <= s_d;
    col_q       <= col_d;
    out_empty_q <= out_empty_d;
    out_last_q  <= out_last_d;
    out_slot_q  <= out_slot_d;
    out_rgb_q   <= out_rgb_d;
  end

  mcq_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (in_rgb),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rd)
  );

  mcq_ram #(.WIDTH(COUNT_BITS), .DEPTH(PALETTE_DEPTH)) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (freq_we),
    .waddr_i (freq_waddr),
    .wdata_i (freq_wdata),
    .raddr_i (freq_raddr),
    .rdata_o (freq_rd)
  );

  mcq_ram #(.WIDTH(COUNT_BITS + 24), .DEPTH(PALETTE_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  mcq_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (bnd_slot_q),
    .wdata_i (box_wdata),
    .raddr_i (box_raddr),
    .rdata_o (box_rd)
  );

  mcq_div #(.DEN_W(WW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (s_q[ch_q]),
    .den_i   (tot_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

endmodule
